[rtl/ffba_pkg.sv]
// shared types and constants of the first-fit block allocator
`default_nettype none

package ffba_pkg;

    localparam int ADDR_BITS        = 24;
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 24;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_OOM     = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    // how a request ends
    typedef enum logic [1:0] {
        FIN_NONE = 2'd0,
        FIN_NULL = 2'd1,
        FIN_HIT  = 2'd2,
        FIN_MISS = 2'd3
    } fin_t;

    // one table entry
    typedef struct packed {
        addr_t offset;
        addr_t size;
        logic  is_free;
    } entry_t;

    typedef struct packed {
        logic load;
        logic step;
        fin_t fin;
    } ffba_ctl_t;

    typedef struct packed {
        logic null_req;
        logic hit;
        logic scan_done;
    } ffba_sts_t;

endpackage : ffba_pkg

`default_nettype wire

[rtl/ffba_ctrl.sv]
// controller state machine of the first-fit block allocator
`default_nettype none

module ffba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ffba_pkg::ffba_sts_t sts,
    output ffba_pkg::ffba_ctl_t     ctl,
    output logic                    busy
);
    import ffba_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '{load: 1'b0, step: 1'b0, fin: FIN_NONE};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_IDLE;
                priority if (sts.null_req)
                    ctl.fin = FIN_NULL;
                else if (sts.hit)
                    ctl.fin = FIN_HIT;
                else if (sts.scan_done)
                    ctl.fin = FIN_MISS;
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule : ffba_ctrl

`default_nettype wire

[rtl/ffba_dp.sv]
// datapath of the first-fit block allocator: block table, heap top and result
`default_nettype none

module ffba_dp #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffba_pkg::ffba_ctl_t ctl,
    output ffba_pkg::ffba_sts_t      sts,
    input  wire logic                cmd,
    input  wire ffba_pkg::addr_t     request_size,
    input  wire ffba_pkg::addr_t     payload_address,
    input  wire logic                heap_limit_we,
    input  wire ffba_pkg::addr_t     heap_limit_wdata,
    output logic                     done,
    output logic [1:0]               status,
    output ffba_pkg::addr_t          result_address
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ADDR_BITS + 2;
    localparam addr_t HDR = ADDR_BITS'(HEADER_BYTES);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    logic              cmd_reg;
    addr_t             size_reg;
    addr_t             addr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [IDX_W-1:0]  eval_idx_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    addr_t             top_reg;
    addr_t             top_next;
    addr_t             limit_reg;
    logic              done_reg;
    status_t           status_reg;
    status_t           status_next;
    addr_t             result_reg;
    addr_t             result_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    addr_t             rd_payload;
    logic              rd_match;
    logic [SUM_W-1:0]  new_top;
    logic              table_full;
    logic              is_last;

    assign rd_payload = rd_data_reg.offset + HDR;
    assign rd_match   = (cmd_reg == CMD_ALLOC)
                        ? (rd_data_reg.is_free && (rd_data_reg.size >= size_reg))
                        : (rd_payload == addr_reg);
    assign new_top    = SUM_W'(top_reg) + SUM_W'(HDR) + SUM_W'(size_reg);
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    assign is_last    = ((CNT_W'(eval_idx_reg) + CNT_W'(1)) == count_reg);

    assign sts.null_req  = (cmd_reg == CMD_ALLOC) ? (size_reg == '0) : (addr_reg == '0);
    assign sts.hit       = rd_valid_reg && rd_match;
    assign sts.scan_done = !rd_valid_reg && (idx_reg == count_reg);

    // scan pointer: one table read issued per step, checked the cycle after
    always_comb
    begin
        idx_next      = idx_reg;
        eval_idx_next = eval_idx_reg;
        rd_valid_next = 1'b0;
        if (ctl.load)
            idx_next = '0;
        else if (ctl.step && (idx_reg < count_reg))
        begin
            idx_next      = idx_reg + CNT_W'(1);
            eval_idx_next = idx_reg[IDX_W-1:0];
            rd_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        status_next = status_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = eval_idx_reg;
        mem_wdata   = rd_data_reg;
        unique case (ctl.fin)
            FIN_NONE:
            begin
            end
            FIN_NULL:
            begin
                status_next = ST_NULL;
                result_next = '0;
            end
            FIN_HIT:
            begin
                status_next = ST_OK;
                if (cmd_reg == CMD_ALLOC)
                begin
                    result_next       = rd_payload;
                    mem_we            = 1'b1;
                    mem_wdata.is_free = 1'b0;
                end
                else
                begin
                    result_next = '0;
                    if (is_last)
                    begin
                        // last block goes away and the top drops back
                        count_next = count_reg - CNT_W'(1);
                        top_next   = rd_data_reg.offset;
                    end
                    else
                    begin
                        mem_we            = 1'b1;
                        mem_wdata.is_free = 1'b1;
                    end
                end
            end
            FIN_MISS:
            begin
                result_next = '0;
                if (cmd_reg == CMD_FREE)
                    status_next = ST_UNKNOWN;
                else if (table_full || (new_top > SUM_W'(limit_reg)))
                    status_next = ST_OOM;
                else
                begin
                    // append a block at the heap top
                    status_next = ST_OK;
                    result_next = top_reg + HDR;
                    mem_we      = 1'b1;
                    mem_waddr   = count_reg[IDX_W-1:0];
                    mem_wdata   = '{offset: top_reg, size: size_reg, is_free: 1'b0};
                    count_next  = count_reg + CNT_W'(1);
                    top_next    = new_top[ADDR_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            size_reg <= request_size;
            addr_reg <= payload_address;
        end
        eval_idx_reg <= eval_idx_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
            top_reg      <= '0;
            limit_reg    <= '1;
            done_reg     <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            done_reg     <= (ctl.fin != FIN_NONE);
            if (heap_limit_we)
                limit_reg <= heap_limit_wdata;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign result_address = result_reg;

endmodule : ffba_dp

`default_nettype wire

[rtl/first_fit_block_allocator.sv]
// first-fit heap allocator over an address-ordered block table
// a request is taken when start is high and busy is low; done pulses one cycle with the result
// a null request ends on its first scan cycle; otherwise table entries are read in order, one per cycle,
// and the scan ends on the first hit or, on a miss, once every block has been read and checked
// a new request is taken at the earliest in the cycle the result shows, so requests never overlap
// reset clears block count, heap top and result strobe and sets heap_limit to all ones
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            cmd,
    input  wire ffba_pkg::addr_t request_size,
    input  wire ffba_pkg::addr_t payload_address,
    input  wire logic            heap_limit_we,
    input  wire ffba_pkg::addr_t heap_limit_wdata,
    output logic                 done,
    output logic [1:0]           status,
    output ffba_pkg::addr_t      result_address
);
    import ffba_pkg::*;

    ffba_ctl_t ctl;
    ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .cmd              (cmd),
        .request_size     (request_size),
        .payload_address  (payload_address),
        .heap_limit_we    (heap_limit_we),
        .heap_limit_wdata (heap_limit_wdata),
        .done             (done),
        .status           (status),
        .result_address   (result_address)
    );

    // every result follows a request's end in the next cycle
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.fin != FIN_NONE))
        else $error("result strobe without a finished request");

    // the controller going idle always comes with a result
    a_idle_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request ended without a result");

    // a nonzero address is only handed out on success
    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_address != '0)) |-> (status == ST_OK))
        else $error("address returned with a failing status");

    // scan steps and finishing never happen in the same cycle
    a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (ctl.fin == FIN_NONE) && busy)
        else $error("scan step overlaps request end");

endmodule : first_fit_block_allocator

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the first-fit block allocator
`timescale 1ns / 1ps

module testbench;

    import ffba_pkg::*;

    localparam int    TABLE_DEPTH    = DEF_MAX_BLOCKS;
    localparam addr_t HEADER_ADDR    = addr_t'(DEF_HEADER_BYTES);
    localparam addr_t LIMIT_ALL_ONES = '1;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    PHASE_ITEMS    = 200;

    typedef struct {
        status_t status;
        addr_t   address;
    } alloc_result_t;

    typedef struct {
        logic    op;
        addr_t   size;
        addr_t   addr;
        logic    typed;
        status_t status;
        addr_t   address;
    } directed_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    cmd;
    addr_t   request_size;
    addr_t   payload_address;
    logic    heap_limit_we;
    addr_t   heap_limit_wdata;
    logic    done;
    logic [1:0] status;
    addr_t   result_address;

    // shadow of the block table and heap registers
    addr_t   tbl_offset [TABLE_DEPTH];
    addr_t   tbl_size   [TABLE_DEPTH];
    logic    tbl_free   [TABLE_DEPTH];
    int      tbl_count;
    addr_t   tbl_top;
    addr_t   tbl_limit;

    alloc_result_t pending_results[$];
    directed_row_t directed_rows[$];

    int mismatch_count;
    int idle_cycles;
    int burst_left;
    int n_requests;
    int n_alloc_ok;
    int n_oom;
    int n_null;
    int n_free_ok;
    int n_unknown;
    int n_limit_writes;
    int peak_count;

    first_fit_block_allocator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .request_size     (request_size),
        .payload_address  (payload_address),
        .heap_limit_we    (heap_limit_we),
        .heap_limit_wdata (heap_limit_wdata),
        .done             (done),
        .status           (status),
        .result_address   (result_address)
    );

    always #2 clk = ~clk;

    function automatic addr_t urand_field(input int unsigned lo, input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[ADDR_BITS-1:0];
    endfunction

    // first-fit allocate / free on the shadow table
    function automatic void allocator_apply(input logic op, input addr_t size, input addr_t addr,
                                            output status_t st, output addr_t ra);
        int idx;
        int hit_idx;
        addr_t payload;
        logic [ADDR_BITS+1:0] new_top;
        st = ST_OK;
        ra = '0;
        hit_idx = -1;
        if (op == CMD_ALLOC)
        begin
            if (size == '0)
            begin
                st = ST_NULL;
            end
            else
            begin
                for (idx = 0; idx < tbl_count; idx++)
                begin
                    if (hit_idx < 0 && tbl_free[idx] && tbl_size[idx] >= size)
                        hit_idx = idx;
                end
                new_top = {2'b00, tbl_top} + {2'b00, HEADER_ADDR} + {2'b00, size};
                if (hit_idx >= 0)
                begin
                    tbl_free[hit_idx] = 1'b0;
                    ra = tbl_offset[hit_idx] + HEADER_ADDR;
                end
                else if (tbl_count >= TABLE_DEPTH || new_top > {2'b00, tbl_limit})
                begin
                    st = ST_OOM;
                end
                else
                begin
                    tbl_offset[tbl_count] = tbl_top;
                    tbl_size[tbl_count]   = size;
                    tbl_free[tbl_count]   = 1'b0;
                    tbl_count++;
                    ra = tbl_top + HEADER_ADDR;
                    tbl_top = new_top[ADDR_BITS-1:0];
                end
            end
        end
        else if (addr == '0)
        begin
            st = ST_NULL;
        end
        else
        begin
            for (idx = 0; idx < tbl_count; idx++)
            begin
                payload = tbl_offset[idx] + HEADER_ADDR;
                if (hit_idx < 0 && payload == addr)
                    hit_idx = idx;
            end
            if (hit_idx < 0)
            begin
                st = ST_UNKNOWN;
            end
            else if (hit_idx == tbl_count - 1)
            begin
                // freeing the top block pulls the heap top back down
                tbl_top = tbl_offset[hit_idx];
                tbl_count--;
            end
            else
            begin
                tbl_free[hit_idx] = 1'b1;
            end
        end
        if (tbl_count > peak_count)
            peak_count = tbl_count;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
    endtask

    task automatic send_request(input logic op, input addr_t size, input addr_t addr,
                                input logic typed, input status_t t_status,
                                input addr_t t_address);
        int gap;
        status_t st;
        addr_t ra;
        alloc_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start           <= 1'b1;
        cmd             <= op;
        request_size    <= size;
        payload_address <= addr;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        allocator_apply(op, size, addr, st, ra);
        if (typed)
        begin
            res.status  = t_status;
            res.address = t_address;
        end
        else
        begin
            res.status  = st;
            res.address = ra;
        end
        pending_results.push_back(res);
        n_requests++;
        unique case (st)
            ST_OK:      if (op == CMD_ALLOC) n_alloc_ok++; else n_free_ok++;
            ST_NULL:    n_null++;
            ST_OOM:     n_oom++;
            ST_UNKNOWN: n_unknown++;
        endcase
    endtask

    task automatic random_request(input int alloc_pct);
        int pick;
        int victim;
        logic op;
        addr_t size;
        addr_t addr;
        op   = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        size = urand_field(0, 32'hFFFFFF);
        addr = urand_field(0, 32'hFFFFFF);
        pick = $urandom_range(0, 19);
        if (op == CMD_ALLOC)
        begin
            if (pick == 0)
                size = '0;
            else if (pick <= 3)
                size = urand_field(1, 32'hFFFF);
            else if (pick > 4)
                size = urand_field(1, 64);
        end
        else if (tbl_count == 0 || pick < 3)
        begin
            if (pick == 0)
                addr = '0;
        end
        else
        begin
            // mostly live blocks, biased toward the top one
            victim = (pick < 8) ? tbl_count - 1 : $urandom_range(0, tbl_count - 1);
            addr = tbl_offset[victim] + HEADER_ADDR;
            if (pick == 3)
                addr = addr + addr_t'(1);
        end
        send_request(op, size, addr, 1'b0, ST_OK, '0);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_heap_limit(input addr_t value);
        heap_limit_we    <= 1'b1;
        heap_limit_wdata <= value;
        @(posedge clk);
        heap_limit_we    <= 1'b0;
        tbl_limit = value;
        n_limit_writes++;
    endtask

    task automatic add_row(input logic op, input addr_t size, input addr_t addr,
                           input logic typed, input status_t st, input addr_t ra);
        directed_row_t row;
        row.op      = op;
        row.size    = size;
        row.addr    = addr;
        row.typed   = typed;
        row.status  = st;
        row.address = ra;
        directed_rows.push_back(row);
    endtask

    // results come back in request order
    always @(posedge clk)
    begin
        alloc_result_t exp_res;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected result, status", 0, 32'(status));
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                    flag_mismatch("status", 32'(exp_res.status), 32'(status));
                if (result_address !== exp_res.address)
                    flag_mismatch("result_address", 32'(exp_res.address),
                                  32'(result_address));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start && busy === 1'b0) || done === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no request or result for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int phase;
        int pct;
        addr_t limit_value;
        alloc_result_t left;
        rst_n            = 1'b0;
        start            = 1'b0;
        cmd              = CMD_ALLOC;
        request_size     = '0;
        payload_address  = '0;
        heap_limit_we    = 1'b0;
        heap_limit_wdata = '0;
        mismatch_count   = 0;
        burst_left       = 0;
        n_requests       = 0;
        n_alloc_ok       = 0;
        n_oom            = 0;
        n_null           = 0;
        n_free_ok        = 0;
        n_unknown        = 0;
        n_limit_writes   = 0;
        peak_count       = 0;
        tbl_count        = 0;
        tbl_top          = '0;
        tbl_limit        = LIMIT_ALL_ONES;

        // null, unknown and out-of-memory rows and some successful ones are typed in, the rest predicted
        add_row(CMD_ALLOC, 24'd0,       24'h5A5A5A, 1'b1, ST_NULL,    24'd0);
        add_row(CMD_FREE,  24'hFFFFFF,  24'd0,      1'b1, ST_NULL,    24'd0);
        add_row(CMD_FREE,  24'd0,       24'd24,     1'b1, ST_UNKNOWN, 24'd0);
        add_row(CMD_ALLOC, 24'd1,       24'hFFFFFF, 1'b1, ST_OK,      24'd24);
        add_row(CMD_ALLOC, 24'hFFFFFF,  24'd0,      1'b1, ST_OOM,     24'd0);
        add_row(CMD_ALLOC, 24'd16,      24'd0,      1'b0, ST_OK,      24'd0);
        add_row(CMD_ALLOC, 24'd8,       24'd0,      1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'd0,       24'd49,     1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'd0,       24'd49,     1'b0, ST_OK,      24'd0);
        add_row(CMD_ALLOC, 24'd20,      24'd0,      1'b0, ST_OK,      24'd0);
        add_row(CMD_ALLOC, 24'd10,      24'd0,      1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'd0,       24'd50,     1'b1, ST_UNKNOWN, 24'd0);
        add_row(CMD_FREE,  24'd0,       24'd121,    1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'd0,       24'd89,     1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'd0,       24'd49,     1'b0, ST_OK,      24'd0);
        add_row(CMD_FREE,  24'hA5A5A5,  24'd24,     1'b1, ST_OK,      24'd0);
        add_row(CMD_ALLOC, 24'hFFFFE7,  24'd0,      1'b1, ST_OK,      24'd24);
        add_row(CMD_ALLOC, 24'd1,       24'd0,      1'b1, ST_OOM,     24'd0);
        add_row(CMD_FREE,  24'd0,       24'hFFFFFF, 1'b1, ST_UNKNOWN, 24'd0);
        add_row(CMD_FREE,  24'd0,       24'd24,     1'b1, ST_OK,      24'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_rows.size(); k++)
            send_request(directed_rows[k].op, directed_rows[k].size, directed_rows[k].addr,
                         directed_rows[k].typed, directed_rows[k].status,
                         directed_rows[k].address);

        // fill every table entry, then ask for more than any entry holds and for a zero size
        settle();
        set_heap_limit(LIMIT_ALL_ONES);
        for (k = 0; k < TABLE_DEPTH; k++)
            send_request(CMD_ALLOC, urand_field(1, 32), '0, 1'b0, ST_OK, '0);
        send_request(CMD_ALLOC, 24'd64, '0, 1'b0, ST_OK, '0);
        send_request(CMD_ALLOC, 24'd0, '0, 1'b0, ST_OK, '0);

        for (phase = 0; phase < 6; phase++)
        begin
            settle();
            unique case (phase)
                0:       limit_value = '0;
                1:       limit_value = urand_field(200, 3000);
                2:       limit_value = urand_field(0, 32'hFFFFFF);
                3:       limit_value = urand_field(1, 600);
                4:       limit_value = urand_field(3000, 8000);
                default: limit_value = LIMIT_ALL_ONES;
            endcase
            set_heap_limit(limit_value);
            pct = 45 + 5 * ((phase * 3) % 6);
            for (k = 0; k < PHASE_ITEMS; k++)
                random_request(pct);
        end

        settle();
        repeat (80) @(posedge clk);

        while (pending_results.size() != 0)
        begin
            left = pending_results.pop_front();
            flag_mismatch("missing result, status", 32'(left.status), 0);
        end

        $display("covered %0d requests over %0d heap_limit settings, table peak %0d of %0d",
                 n_requests, n_limit_writes, peak_count, TABLE_DEPTH);
        $display("allocs ok %0d, frees ok %0d, null %0d, out of memory %0d, unknown %0d",
                 n_alloc_ok, n_free_ok, n_null, n_oom, n_unknown);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
